// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the capture block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/pwc_pkg.sv =====
// ---------------------------------------------------------------------------
// pwc_pkg
// Types and constants shared by the pulse width capture block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwc_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W         = 2;
	localparam int CAP_W        = 16;
	localparam int TICK_W       = 32;
	localparam int COUNTER_SPAN = 65536;

	localparam logic OP_CAPTURE  = 1'b0;
	localparam logic OP_OVERFLOW = 1'b1;

	localparam int  PADDR_W    = 3;
	localparam int  PDATA_W    = 32;
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_OVF    = 1'b1;

	typedef struct packed {
		logic [NUM_CHANNELS-1:0] enable_mask;
		logic                    ovf_enable;
	} cfg_t;

	typedef struct packed {
		logic             opcode;
		logic [CH_W-1:0]  channel;
		logic [CAP_W-1:0] captured_value;
		logic             pin_level;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]   result_channel;
		logic [TICK_W-1:0] low_ticks;
		logic [TICK_W-1:0] high_ticks;
		logic [TICK_W-1:0] period_ticks;
	} result_t;

endpackage

// ===== src/pwc_in_if.sv =====
// ---------------------------------------------------------------------------
// pwc_in_if
// Event channel: capture and overflow items with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pwc_in_if
	import pwc_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [CH_W-1:0]  channel;
	logic [CAP_W-1:0] captured_value;
	logic             pin_level;

	modport source (output valid, opcode, channel, captured_value, pin_level, input ready);
	modport sink (input valid, opcode, channel, captured_value, pin_level, output ready);
endinterface

// ===== src/pwc_out_if.sv =====
// ---------------------------------------------------------------------------
// pwc_out_if
// Result channel: per-channel measurements with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pwc_out_if
	import pwc_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   result_channel;
	logic [TICK_W-1:0] low_ticks;
	logic [TICK_W-1:0] high_ticks;
	logic [TICK_W-1:0] period_ticks;

	modport source (output valid, result_channel, low_ticks, high_ticks, period_ticks,
		input ready);
	modport sink (input valid, result_channel, low_ticks, high_ticks, period_ticks,
		output ready);
endinterface

// ===== src/pwc_cfg.sv =====
// ---------------------------------------------------------------------------
// pwc_cfg
// APB register file: channel enable mask and overflow enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwc_cfg
	import pwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ENABLE: cfg_q.enable_mask <= pwdata[NUM_CHANNELS-1:0];
				REG_OVF:    cfg_q.ovf_enable  <= pwdata[0];
				default:    cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_ENABLE: prdata[NUM_CHANNELS-1:0] = cfg_q.enable_mask;
			REG_OVF:    prdata[0]                = cfg_q.ovf_enable;
			default:    prdata                   = '0;
		endcase
	end

endmodule

// ===== src/pwc_core.sv =====
// ---------------------------------------------------------------------------
// pwc_core
// Per-channel accumulators and durations; one item's update and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwc_core
	import pwc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    fire,
	output logic    res_valid,
	output result_t res
);
	`include "assert_macros.svh"

	logic signed [TICK_W-1:0] acc_q  [NUM_CHANNELS];
	logic        [TICK_W-1:0] low_q  [NUM_CHANNELS];
	logic        [TICK_W-1:0] high_q [NUM_CHANNELS];

	logic signed [TICK_W:0]   cap_sum;
	logic signed [TICK_W-1:0] total;
	logic        [TICK_W-1:0] dur;
	logic        [TICK_W-1:0] low_new;
	logic        [TICK_W-1:0] high_new;
	logic        [TICK_W:0]   period_sum;
	logic        [TICK_W-1:0] acc_restart;
	logic                     in_range;
	logic                     do_capture;
	logic                     do_overflow;

	function automatic logic [TICK_W-1:0] sat_s32(input logic [TICK_W:0] v);
		logic [TICK_W-1:0] r;
		if (v[TICK_W] != v[TICK_W-1]) begin
			r = v[TICK_W] ? {1'b1, {(TICK_W-1){1'b0}}} : {1'b0, {(TICK_W-1){1'b1}}};
		end else begin
			r = v[TICK_W-1:0];
		end
		return r;
	endfunction

	assign in_range    = 32'(item.channel) < NUM_CHANNELS;
	assign do_capture  = (item.opcode == OP_CAPTURE) && in_range
		&& cfg.enable_mask[item.channel];
	assign do_overflow = (item.opcode == OP_OVERFLOW) && cfg.ovf_enable;
	assign res_valid   = do_capture;

	always_comb begin
		cap_sum     = {acc_q[item.channel][TICK_W-1], acc_q[item.channel]}
			+ {{(TICK_W-CAP_W+1){1'b0}}, item.captured_value};
		total       = $signed(sat_s32(cap_sum));
		dur         = total[TICK_W-1] ? '0 : total;
		low_new     = item.pin_level ? dur : low_q[item.channel];
		high_new    = item.pin_level ? high_q[item.channel] : dur;
		period_sum  = {1'b0, low_new} + {1'b0, high_new};
		acc_restart = '0 - {{(TICK_W-CAP_W){1'b0}}, item.captured_value};
	end

	always_comb begin
		res.result_channel = item.channel;
		res.low_ticks      = low_new;
		res.high_ticks     = high_new;
		res.period_ticks   = period_sum[TICK_W] ? '1 : period_sum[TICK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				acc_q[c]  <= '0;
				low_q[c]  <= '0;
				high_q[c] <= '0;
			end
		end else if (fire) begin
			if (do_overflow) begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					acc_q[c] <= $signed(sat_s32({acc_q[c][TICK_W-1], acc_q[c]}
						+ (TICK_W+1)'(COUNTER_SPAN)));
				end
			end else if (do_capture) begin
				acc_q[item.channel]  <= $signed(acc_restart);
				low_q[item.channel]  <= low_new;
				high_q[item.channel] <= high_new;
			end
		end
	end

	`ASSERT_IMPL(a_dur_nonneg, clk, arst_n, res_valid,
		!res.low_ticks[TICK_W-1] && !res.high_ticks[TICK_W-1], "duration above signed range")

endmodule

// ===== src/pulse_width_capture.sv =====
// ---------------------------------------------------------------------------
// pulse_width_capture
// Pulse width measurement on four capture channels of a 16-bit counter.
// ---------------------------------------------------------------------------
// Usage:
//   events  : capture (channel, captured value, pin level) or counter overflow
//             items, valid/ready.
//   results : one item per capture on an enabled channel: low, high and
//             period ticks of that channel. Overflows never give a result.
//   APB     : 0x0 channel enable mask, 0x4 overflow enable; write only while
//             idle.
// Path: an accepted item is held in the input register, where the channel
//   update is done; its result is then offered from the result register.
// Throughput: one item per cycle unless a held result stalls it, set by the single add-and-store per item.
// Reset: accumulators, durations and registers clear; both channels empty.
// Stall: a held result blocks only a following item that also gives a
//   result; the input register then holds and ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_width_capture
	import pwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pwc_in_if.sink             events,
	pwc_out_if.source          results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	`include "assert_macros.svh"

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    res_valid;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    adv_s1;
	logic    load_out;
	logic    in_fire;

	pwc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item_s1),
		.fire      (adv_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_free      = !out_valid_q || results.ready;
	assign adv_s1        = valid_s1 && (!res_valid || out_free);
	assign load_out      = adv_s1 && res_valid;
	assign events.ready  = !valid_s1 || adv_s1;
	assign in_fire       = events.valid && events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode         <= events.opcode;
			item_s1.channel        <= events.channel;
			item_s1.captured_value <= events.captured_value;
			item_s1.pin_level      <= events.pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.result_channel = res_q.result_channel;
	assign results.low_ticks      = res_q.low_ticks;
	assign results.high_ticks     = res_q.high_ticks;
	assign results.period_ticks   = res_q.period_ticks;

	`ASSERT_IMPL(a_stall_cause, clk, arst_n, valid_s1 && !adv_s1,
		out_valid_q && !results.ready, "input register stalled without back-pressure")
	`ASSERT_IMPL(a_period_bound, clk, arst_n, out_valid_q,
		res_q.period_ticks >= res_q.low_ticks && res_q.period_ticks >= res_q.high_ticks,
		"period below a component")
	`ASSERT_CLK(a_load_shows, clk, arst_n, load_out |=> out_valid_q, "loaded result not offered")

endmodule

// ===== tb/sv/pwc_checker.sv =====
// ---------------------------------------------------------------------------
// pwc_checker
// Watches the event, result and APB ports of the pulse width capture block,
// keeps its own copy of the channel accumulators, durations and registers,
// predicts the measurement of each accepted capture and compares every
// accepted result with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwc_checker
	import pwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pwc_in_if                  ev,
	pwc_out_if                 res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatch_count,
	output int                 measurements_due
);

	localparam longint ACC_MAX = 64'sd2147483647;
	localparam longint ACC_MIN = -64'sd2147483648;

	cfg_t                     cfg;
	logic signed [TICK_W-1:0] edge_acc [NUM_CHANNELS];
	logic [TICK_W-1:0]        low_len  [NUM_CHANNELS];
	logic [TICK_W-1:0]        high_len [NUM_CHANNELS];
	result_t                  due_measurements [$];

	function automatic logic signed [TICK_W-1:0] sat_acc(input longint v);
		if (v > ACC_MAX)
			return TICK_W'(ACC_MAX);
		if (v < ACC_MIN)
			return TICK_W'(ACC_MIN);
		return TICK_W'(v);
	endfunction

	// returns 1 when the item yields a measurement
	function automatic bit predict_measurement(input item_t it, output result_t m);
		longint            cap;
		longint            total;
		logic [TICK_W-1:0] width;
		longint unsigned   sum;
		cap = longint'(it.captured_value);
		m = '0;
		if (it.opcode == OP_OVERFLOW) begin
			if (cfg.ovf_enable)
				for (int c = 0; c < NUM_CHANNELS; c++)
					edge_acc[c] = sat_acc(longint'(edge_acc[c]) + COUNTER_SPAN);
			return 0;
		end
		if (int'(it.channel) >= NUM_CHANNELS || !cfg.enable_mask[it.channel])
			return 0;
		total = longint'(sat_acc(longint'(edge_acc[it.channel]) + cap));
		width = (total < 0) ? '0 : TICK_W'(total);
		if (it.pin_level)
			low_len[it.channel] = width;
		else
			high_len[it.channel] = width;
		edge_acc[it.channel] = sat_acc(-cap);
		sum = longint'(low_len[it.channel]) + longint'(high_len[it.channel]);
		m.result_channel = it.channel;
		m.low_ticks      = low_len[it.channel];
		m.high_ticks     = high_len[it.channel];
		m.period_ticks   = (sum > 64'hFFFF_FFFF) ? '1 : TICK_W'(sum);
		return 1;
	endfunction

	task automatic check_field(input string name, input logic [TICK_W-1:0] want,
			input logic [TICK_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t m;
		if (!arst_n) begin
			cfg = '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				edge_acc[c] = '0;
				low_len[c]  = '0;
				high_len[c] = '0;
			end
			due_measurements.delete();
			mismatch_count = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (due_measurements.size() == 0) begin
					$display("%0t: unexpected result, expected none, got ch %0d low %0d high %0d period %0d",
						$time, res.result_channel, res.low_ticks, res.high_ticks,
						res.period_ticks);
					mismatch_count++;
				end else begin
					m = due_measurements.pop_front();
					check_field("result_channel", TICK_W'(m.result_channel),
						TICK_W'(res.result_channel));
					check_field("low_ticks", m.low_ticks, res.low_ticks);
					check_field("high_ticks", m.high_ticks, res.high_ticks);
					check_field("period_ticks", m.period_ticks, res.period_ticks);
				end
			end
			if (ev.valid && ev.ready) begin
				it.opcode         = ev.opcode;
				it.channel        = ev.channel;
				it.captured_value = ev.captured_value;
				it.pin_level      = ev.pin_level;
				if (predict_measurement(it, m))
					due_measurements.push_back(m);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[PADDR_W-1:2] == REG_ENABLE)
					cfg.enable_mask = pwdata[NUM_CHANNELS-1:0];
				else if (paddr[PADDR_W-1:2] == REG_OVF)
					cfg.ovf_enable = pwdata[0];
			end
		end
		measurements_due = due_measurements.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Stimulus for the pulse width capture block: directed captures and
// overflows around disabled channels, negative totals and extreme counter
// values, random phases under several register settings with random gaps on
// both sides and one long result hold-off, and two runs of overflows between captures.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pwc_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 4000;
	localparam int OVF_RUN     = 20;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 mismatch_count;
	int                 measurements_due;
	int                 quiet_cycles;
	bit                 gaps_on;
	bit                 hold_req;
	logic               level [NUM_CHANNELS];

	pwc_in_if  ev_if ();
	pwc_out_if res_if ();

	pulse_width_capture uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_if),
		.results (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pwc_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.ev               (ev_if),
		.res              (res_if),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.pready           (pready),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.mismatch_count   (mismatch_count),
		.measurements_due (measurements_due)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end else begin
				res_if.ready <= !(gaps_on && $urandom_range(99) < 14);
			end
		end
	end

	task automatic send_event(input logic op, input logic [CH_W-1:0] ch,
			input logic [CAP_W-1:0] cap, input logic pin);
		while (gaps_on && $urandom_range(99) < 14) begin
			ev_if.valid <= 1'b0;
			@(negedge clk);
		end
		ev_if.valid          <= 1'b1;
		ev_if.opcode         <= op;
		ev_if.channel        <= ch;
		ev_if.captured_value <= cap;
		ev_if.pin_level      <= pin;
		@(posedge clk);
		while (!ev_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drain all results, then allow for an overflow still in the pipe
	task automatic settle();
		ev_if.valid <= 1'b0;
		while (measurements_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [NUM_CHANNELS-1:0] mask, input logic ovf);
		settle();
		write_reg(REG_ENABLE, PDATA_W'(mask));
		@(negedge clk);
		write_reg(REG_OVF, PDATA_W'(ovf));
	endtask

	// mostly alternating pin levels per channel, overflows mixed in
	task automatic random_events(input int count, input int ovf_pct);
		logic [CH_W-1:0]  ch;
		logic [CAP_W-1:0] cap;
		logic             pin;
		for (int k = 0; k < count; k++) begin
			ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
			case ($urandom_range(9))
				0: cap = '0;
				1: cap = '1;
				default: cap = CAP_W'($urandom);
			endcase
			if ($urandom_range(99) < 85)
				pin = !level[ch];
			else
				pin = 1'($urandom);
			if ($urandom_range(99) < ovf_pct) begin
				send_event(OP_OVERFLOW, ch, cap, pin);
			end else begin
				level[ch] = pin;
				send_event(OP_CAPTURE, ch, cap, pin);
			end
		end
	endtask

	task automatic overflow_run(input int count);
		for (int k = 0; k < count; k++)
			send_event(OP_OVERFLOW, CH_W'($urandom), CAP_W'($urandom), 1'($urandom));
	endtask

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		ev_if.valid          = 1'b0;
		ev_if.opcode         = OP_CAPTURE;
		ev_if.channel        = '0;
		ev_if.captured_value = '0;
		ev_if.pin_level      = 1'b0;
		gaps_on              = 1'b1;
		hold_req             = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++)
			level[c] = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers at reset: everything ignored
		send_event(OP_CAPTURE, 2'd0, 16'h1234, 1'b1);
		send_event(OP_OVERFLOW, 2'd0, 16'h0000, 1'b0);
		// overflow also extends a disabled channel
		configure(4'b0111, 1'b1);
		send_event(OP_OVERFLOW, 2'd3, 16'hFFFF, 1'b1);
		send_event(OP_CAPTURE, 2'd3, 16'h0005, 1'b1);
		configure(4'b1111, 1'b1);
		send_event(OP_CAPTURE, 2'd3, 16'h0010, 1'b0);
		send_event(OP_CAPTURE, 2'd0, 16'h0000, 1'b1);
		send_event(OP_CAPTURE, 2'd0, 16'hFFFF, 1'b0);
		send_event(OP_OVERFLOW, 2'd1, 16'h5A5A, 1'b0);
		send_event(OP_OVERFLOW, 2'd2, 16'hA5A5, 1'b1);
		send_event(OP_CAPTURE, 2'd0, 16'h8000, 1'b1);
		// negative totals without counted overflows
		send_event(OP_CAPTURE, 2'd1, 16'hFFFF, 1'b1);
		send_event(OP_CAPTURE, 2'd1, 16'h0000, 1'b0);
		send_event(OP_CAPTURE, 2'd2, 16'hAAAA, 1'b0);
		send_event(OP_CAPTURE, 2'd2, 16'h5555, 1'b1);
		send_event(OP_CAPTURE, 2'd1, 16'hFFFF, 1'b1);
		send_event(OP_CAPTURE, 2'd3, 16'h7FFF, 1'b1);

		hold_req = 1'b1;
		random_events(150, 20);
		configure(4'($urandom_range(1, 14)), 1'b1);
		random_events(100, 25);
		configure(4'b1111, 1'b0);
		random_events(100, 20);
		configure(4'b0000, 1'b1);
		random_events(30, 30);
		configure(4'b1111, 1'b1);
		gaps_on = 1'b0;
		random_events(150, 20);
		gaps_on = 1'b1;
		configure(4'($urandom), 1'($urandom));
		random_events(100, 25);

		// long overflow stretches between captures, low then high
		configure(4'b1111, 1'b1);
		send_event(OP_CAPTURE, 2'd2, 16'h0000, 1'b1);
		overflow_run(OVF_RUN);
		send_event(OP_CAPTURE, 2'd2, 16'hFFFF, 1'b1);
		overflow_run(OVF_RUN);
		send_event(OP_CAPTURE, 2'd2, 16'hFFFF, 1'b0);
		random_events(40, 20);

		settle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && measurements_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
